>>> sv/rswi_pkg.sv
// ----------------------------------------------------------------------------
// rswi_pkg
// Shared types and codes for the reservation station wakeup/issue block.
// ----------------------------------------------------------------------------
package rswi_pkg;

   // operation codes carried on req_tuser
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_WAKEUP = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // response status codes carried on rsp_tuser
   localparam logic STATUS_ISSUED   = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // per-cell control strobes
   typedef struct packed {
      logic clear;   // drop every entry
      logic insert;  // write the insert beat into pending
      logic wakeup;  // match the broadcast tag against pending waits
      logic commit;  // copy pending into committed
      logic shift;   // committed takes neighbor's committed
      logic free;    // issued this tick: pending goes not busy
   } cell_ctrl_type;

endpackage

>>> sv/reservation_station_wakeup_issue.sv
// ----------------------------------------------------------------------------
// reservation_station_wakeup_issue
// Tomasulo reservation station built as a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//  req_* beats carry one command (req_tuser): insert, wakeup, tick, clear.
//  rsp_* beats carry issued operations (rsp_tuser = 0) or an insert reject
//  (rsp_tuser = 1); rsp_tlast marks the final beat caused by a command.
//  Insert, wakeup and clear give no beat, except a reject on a full
//  station, which shows on rsp in the cycle after the insert.
//  A tick with exec_free set and ready committed entries walks the
//  committed table through the ring one entry per cycle while the output
//  register can load, the head cell feeding the output register; it visits
//  entries from index 0 up to the highest ready one. The walk stops after
//  the last ready entry and pending is then copied into committed.
//  req_tready is high only while idle with the output register empty, so
//  a command that gives a beat holds off the next one until the beat is taken.
//  Reset (synchronous) empties both tables; no clearing pass is needed.
//  A stalled receiver holds the output beat and freezes the walk.
// ----------------------------------------------------------------------------
module reservation_station_wakeup_issue #(
   parameter int ENTRIES    = 16,
   parameter int TAG_COUNT  = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, low bit up: opcode, uses_immediate, is_load, first_value,
   // second_value, first_wait_tag, second_wait_tag, immediate, dest_tag,
   // exec_free, zero fill
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((3*DATA_WIDTH+3*$clog2(TAG_COUNT)+11+7)/8)*8-1:0] req_tdata,
   input  logic [1:0]                                req_tuser,  // operation
   // rsp_tdata, low bit up: issued_opcode, first_operand, second_operand,
   // result_tag, to_load_store, zero fill
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((2*DATA_WIDTH+$clog2(TAG_COUNT)+7+7)/8)*8-1:0] rsp_tdata,
   output logic                                      rsp_tuser,  // status
   output logic                                      rsp_tlast
);

   localparam int TAG_W  = $clog2(TAG_COUNT);
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int OUT_W  = 2*DATA_WIDTH + TAG_W + 7;
   localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;
   localparam int O_FV   = 8;
   localparam int O_SV   = O_FV + DATA_WIDTH;
   localparam int O_FW   = O_SV + DATA_WIDTH;
   localparam int O_SW   = O_FW + TAG_W + 1;
   localparam int O_IM   = O_SW + TAG_W + 1;
   localparam int O_DT   = O_IM + DATA_WIDTH;
   localparam int O_EF   = O_DT + TAG_W;

   // request fields
   logic [5:0]            f_opcode;
   logic [1:0]            f_kind;
   logic [DATA_WIDTH-1:0] f_first, f_second, f_imm;
   logic [TAG_W:0]        f_fwait, f_swait;
   logic [TAG_W-1:0]      f_tag;
   logic                  f_exec_free;

   assign f_opcode    = req_tdata[5:0];
   assign f_kind      = req_tdata[7:6];   // bit 0 immediate form, bit 1 load
   assign f_first     = req_tdata[O_FV +: DATA_WIDTH];
   assign f_second    = req_tdata[O_SV +: DATA_WIDTH];
   assign f_fwait     = req_tdata[O_FW +: TAG_W+1];
   assign f_swait     = req_tdata[O_SW +: TAG_W+1];
   assign f_imm       = req_tdata[O_IM +: DATA_WIDTH];
   assign f_tag       = req_tdata[O_DT +: TAG_W];
   assign f_exec_free = req_tdata[O_EF];

   // ring wires
   logic                  c_busy   [ENTRIES];
   logic [5:0]            c_opcode [ENTRIES];
   logic [1:0]            c_kind   [ENTRIES];
   logic [DATA_WIDTH-1:0] c_first  [ENTRIES];
   logic [DATA_WIDTH-1:0] c_second [ENTRIES];
   logic [DATA_WIDTH-1:0] c_imm    [ENTRIES];
   logic [TAG_W:0]        c_fwait  [ENTRIES];
   logic [TAG_W:0]        c_swait  [ENTRIES];
   logic [TAG_W-1:0]      c_tag    [ENTRIES];
   logic [ENTRIES-1:0]    ready_vec, busy_vec;
   rswi_pkg::cell_ctrl_type ctrl [ENTRIES];

   // control state
   rswi_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ENTRIES-1:0]  mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BW-1:0]   rsp_data_ff;
   logic                rsp_status_ff, rsp_last_ff;

   logic               accept, slot_free;
   logic               do_insert, do_wakeup, do_clear, do_tick;
   logic               tick_commit, scan_emit, scan_shift, scan_commit, reject;
   logic [ENTRIES-1:0] free_vec, ins_onehot, idx_onehot, mask_left;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign do_insert = accept && (req_tuser == rswi_pkg::OP_INSERT);
   assign do_wakeup = accept && (req_tuser == rswi_pkg::OP_WAKEUP);
   assign do_tick   = accept && (req_tuser == rswi_pkg::OP_TICK);
   assign do_clear  = accept && (req_tuser == rswi_pkg::OP_CLEAR);

   // lowest free committed entry
   assign free_vec   = ~busy_vec;
   assign ins_onehot = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
   assign reject     = do_insert && (&busy_vec);

   // tick with nothing to issue commits at once
   assign tick_commit = do_tick && !(f_exec_free && (|ready_vec));

   assign idx_onehot  = {{(ENTRIES-1){1'b0}}, 1'b1} << idx_ff;
   assign mask_left   = mask_ff & ~idx_onehot;
   assign scan_emit   = (state_ff == rswi_pkg::ST_SCAN) && slot_free && (|(mask_ff & idx_onehot));
   assign scan_commit = (state_ff == rswi_pkg::ST_SCAN) && slot_free && (mask_left == '0);
   assign scan_shift  = (state_ff == rswi_pkg::ST_SCAN) && slot_free && (mask_left != '0);

   assign req_tready = (state_ff == rswi_pkg::ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         rswi_pkg::ST_IDLE: begin
            if (do_tick && !tick_commit) begin
               state_in = rswi_pkg::ST_SCAN;
               idx_in   = '0;
               mask_in  = ready_vec;
            end
            if (reject) begin
               rsp_valid_in = 1'b1;
            end
         end
         rswi_pkg::ST_SCAN: begin
            if (scan_emit) begin
               rsp_valid_in = 1'b1;
            end
            if (scan_commit) begin
               state_in = rswi_pkg::ST_IDLE;
            end else if (scan_shift) begin
               idx_in  = idx_ff + 1'b1;
               mask_in = mask_left;
            end
         end
         default: begin
            state_in = rswi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rswi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      mask_ff <= mask_in;

      // output beat: head cell holds the entry being walked
      if (reject) begin
         rsp_data_ff   <= '0;
         rsp_status_ff <= rswi_pkg::STATUS_REJECTED;
         rsp_last_ff   <= 1'b1;
      end else if (scan_emit) begin
         rsp_data_ff <= OUT_BW'({c_kind[0][1], c_tag[0],
                                 (c_kind[0][0] ? c_imm[0] : c_second[0]),
                                 c_first[0], c_opcode[0]});
         rsp_status_ff <= rswi_pkg::STATUS_ISSUED;
         rsp_last_ff   <= (mask_left == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      localparam int NX = (g + 1) % ENTRIES;

      assign busy_vec[g]     = c_busy[g];
      assign ctrl[g].clear   = do_clear;
      assign ctrl[g].insert  = do_insert && !reject && ins_onehot[g];
      assign ctrl[g].wakeup  = do_wakeup;
      assign ctrl[g].commit  = tick_commit || scan_commit;
      assign ctrl[g].shift   = scan_shift;
      assign ctrl[g].free    = scan_emit && idx_onehot[g];

      rswi_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .TAG_W      (TAG_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[g]),
         .in_opcode (f_opcode),
         .in_kind   (f_kind),
         .in_first  (f_first),
         .in_second (f_second),
         .in_imm    (f_imm),
         .in_fwait  (f_fwait),
         .in_swait  (f_swait),
         .in_tag    (f_tag),
         .n_busy    (c_busy[NX]),
         .n_opcode  (c_opcode[NX]),
         .n_kind    (c_kind[NX]),
         .n_first   (c_first[NX]),
         .n_second  (c_second[NX]),
         .n_imm     (c_imm[NX]),
         .n_fwait   (c_fwait[NX]),
         .n_swait   (c_swait[NX]),
         .n_tag     (c_tag[NX]),
         .c_busy    (c_busy[g]),
         .c_opcode  (c_opcode[g]),
         .c_kind    (c_kind[g]),
         .c_first   (c_first[g]),
         .c_second  (c_second[g]),
         .c_imm     (c_imm[g]),
         .c_fwait   (c_fwait[g]),
         .c_swait   (c_swait[g]),
         .c_tag     (c_tag[g]),
         .c_ready   (ready_vec[g])
      );
   end

endmodule

>>> sv/rswi_cell.sv
// ----------------------------------------------------------------------------
// rswi_cell
// One station entry: pending and committed copy, wakeup match, ready flag.
// ----------------------------------------------------------------------------
module rswi_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int TAG_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rswi_pkg::cell_ctrl_type ctrl,
   // insert / wakeup beat
   input  logic [5:0]            in_opcode,
   input  logic [1:0]            in_kind,
   input  logic [DATA_WIDTH-1:0] in_first,
   input  logic [DATA_WIDTH-1:0] in_second,
   input  logic [DATA_WIDTH-1:0] in_imm,
   input  logic [TAG_W:0]        in_fwait,
   input  logic [TAG_W:0]        in_swait,
   input  logic [TAG_W-1:0]      in_tag,
   // committed entry of the next cell in the ring
   input  logic                  n_busy,
   input  logic [5:0]            n_opcode,
   input  logic [1:0]            n_kind,
   input  logic [DATA_WIDTH-1:0] n_first,
   input  logic [DATA_WIDTH-1:0] n_second,
   input  logic [DATA_WIDTH-1:0] n_imm,
   input  logic [TAG_W:0]        n_fwait,
   input  logic [TAG_W:0]        n_swait,
   input  logic [TAG_W-1:0]      n_tag,
   // committed entry of this cell
   output logic                  c_busy,
   output logic [5:0]            c_opcode,
   output logic [1:0]            c_kind,
   output logic [DATA_WIDTH-1:0] c_first,
   output logic [DATA_WIDTH-1:0] c_second,
   output logic [DATA_WIDTH-1:0] c_imm,
   output logic [TAG_W:0]        c_fwait,
   output logic [TAG_W:0]        c_swait,
   output logic [TAG_W-1:0]      c_tag,
   output logic                  c_ready
);

   logic                  p_busy_ff,   c_busy_ff;
   logic [5:0]            p_opcode_ff, c_opcode_ff;
   logic [1:0]            p_kind_ff,   c_kind_ff;
   logic [DATA_WIDTH-1:0] p_first_ff,  c_first_ff;
   logic [DATA_WIDTH-1:0] p_second_ff, c_second_ff;
   logic [DATA_WIDTH-1:0] p_imm_ff,    c_imm_ff;
   logic [TAG_W:0]        p_fwait_ff,  c_fwait_ff;
   logic [TAG_W:0]        p_swait_ff,  c_swait_ff;
   logic [TAG_W-1:0]      p_tag_ff,    c_tag_ff;

   logic hit_first, hit_second;

   // sign bit set means no wait
   assign hit_first  = p_busy_ff && !p_fwait_ff[TAG_W] && (p_fwait_ff[TAG_W-1:0] == in_tag);
   assign hit_second = p_busy_ff && !hit_first && !p_swait_ff[TAG_W]
                       && (p_swait_ff[TAG_W-1:0] == in_tag);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         p_busy_ff <= 1'b0;
      end else if (ctrl.insert) begin
         p_busy_ff <= 1'b1;
      end else if (ctrl.free) begin
         p_busy_ff <= 1'b0;
      end

      if (ctrl.insert) begin
         p_opcode_ff <= in_opcode;
         p_kind_ff   <= in_kind;
         p_first_ff  <= in_first;
         p_second_ff <= in_second;
         p_imm_ff    <= in_imm;
         p_fwait_ff  <= in_fwait;
         p_swait_ff  <= in_swait;
         p_tag_ff    <= in_tag;
      end else if (ctrl.wakeup) begin
         if (hit_first) begin
            p_first_ff <= in_first;
            p_fwait_ff <= {1'b1, {TAG_W{1'b1}}};
         end else if (hit_second) begin
            p_second_ff <= in_first;
            p_swait_ff  <= {1'b1, {TAG_W{1'b1}}};
         end
      end

      if (reset || ctrl.clear) begin
         c_busy_ff <= 1'b0;
      end else if (ctrl.commit) begin
         c_busy_ff <= p_busy_ff && !ctrl.free;
      end else if (ctrl.shift) begin
         c_busy_ff <= n_busy;
      end

      if (ctrl.commit) begin
         c_opcode_ff <= p_opcode_ff;
         c_kind_ff   <= p_kind_ff;
         c_first_ff  <= p_first_ff;
         c_second_ff <= p_second_ff;
         c_imm_ff    <= p_imm_ff;
         c_fwait_ff  <= p_fwait_ff;
         c_swait_ff  <= p_swait_ff;
         c_tag_ff    <= p_tag_ff;
      end else if (ctrl.shift) begin
         c_opcode_ff <= n_opcode;
         c_kind_ff   <= n_kind;
         c_first_ff  <= n_first;
         c_second_ff <= n_second;
         c_imm_ff    <= n_imm;
         c_fwait_ff  <= n_fwait;
         c_swait_ff  <= n_swait;
         c_tag_ff    <= n_tag;
      end
   end

   assign c_busy   = c_busy_ff;
   assign c_opcode = c_opcode_ff;
   assign c_kind   = c_kind_ff;
   assign c_first  = c_first_ff;
   assign c_second = c_second_ff;
   assign c_imm    = c_imm_ff;
   assign c_fwait  = c_fwait_ff;
   assign c_swait  = c_swait_ff;
   assign c_tag    = c_tag_ff;
   assign c_ready  = c_busy_ff && c_fwait_ff[TAG_W] && (c_kind_ff[0] || c_swait_ff[TAG_W]);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: reservation station wakeup/issue bench
// Drives insert, wakeup, tick and clear beats with random gaps, predicts the
// issued operations and insert rejects from a two-table model of the
// station, and compares every response beat field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_ENTRIES = 16;
   localparam int RANDOM_BEATS = 360;
   localparam int IDLE_LIMIT = 5000;    // cycles with no beat on either side
   localparam int LONG_HOLD = 300;      // receiver hold-off to fill the station
   localparam logic [5:0] READY_TAG = 6'h3f;

   // one command beat
   typedef struct {
      logic [1:0]  op;
      logic [5:0]  opcode;
      logic        uses_imm;
      logic        is_load;
      logic [31:0] first;
      logic [31:0] second;
      logic [5:0]  first_wait;
      logic [5:0]  second_wait;
      logic [31:0] imm;
      logic [4:0]  dest;
      logic        exec_free;
   } cmd_type;

   // one response beat
   typedef struct packed {
      logic        status;
      logic [5:0]  opcode;
      logic [31:0] first;
      logic [31:0] second;
      logic [4:0]  tag;
      logic        to_ls;
      logic        last;
   } issue_type;

   // one station slot
   typedef struct {
      logic        busy;
      logic [5:0]  opcode;
      logic [1:0]  kind;    // bit 0 immediate form, bit 1 load-store route
      logic [31:0] first;
      logic [31:0] second;
      logic [31:0] imm;
      logic [5:0]  first_wait;
      logic [5:0]  second_wait;
      logic [4:0]  tag;
   } slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;  // opcode, uses_imm, is_load, first, second,
                                  // first_wait, second_wait, imm, dest,
                                  // exec_free, zero fill
   logic [1:0] req_tuser = rswi_pkg::OP_INSERT;  // operation
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // opcode, first, second, tag, to_ls, zero fill
   logic rsp_tuser;               // status
   logic rsp_tlast;

   reservation_station_wakeup_issue uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   slot_type committed_tbl [NUM_ENTRIES];
   slot_type pending_tbl [NUM_ENTRIES];
   issue_type expected_issues [$];
   int mismatches = 0;
   int beats_seen = 0;
   int rejects_seen = 0;
   int commands_sent = 0;
   int idle_cycles = 0;
   bit long_hold_req = 1'b0;

   function automatic void clear_tables();
      foreach (committed_tbl[i]) begin
         committed_tbl[i] = '{busy: 1'b0, opcode: '0, kind: '0, first: '0, second: '0,
                              imm: '0, first_wait: READY_TAG, second_wait: READY_TAG,
                              tag: '0};
         pending_tbl[i] = committed_tbl[i];
      end
   endfunction

   // sign bit set on a wait tag means the operand is already there
   function automatic bit waiting(logic [5:0] w);
      return !w[5];
   endfunction

   // advance the station model by one command, queueing the beats it causes
   function automatic void station_step(cmd_type c, bit keep);
      int slot;
      int n;
      bit imm_form;
      issue_type r;
      slot = -1;
      n = 0;
      case (c.op)
         rswi_pkg::OP_INSERT: begin
            for (int i = NUM_ENTRIES - 1; i >= 0; i--)
               if (!committed_tbl[i].busy) slot = i;
            if (slot < 0) begin
               r = '0;
               r.status = rswi_pkg::STATUS_REJECTED;
               r.last = 1'b1;
               if (keep) expected_issues.push_back(r);
            end else begin
               pending_tbl[slot] = '{busy: 1'b1, opcode: c.opcode,
                                     kind: {c.is_load, c.uses_imm}, first: c.first,
                                     second: c.second, imm: c.imm,
                                     first_wait: c.first_wait,
                                     second_wait: c.second_wait, tag: c.dest};
            end
         end
         rswi_pkg::OP_WAKEUP: begin
            foreach (pending_tbl[i]) begin
               if (!pending_tbl[i].busy) continue;
               // first wait wins; second only checked on a first-wait miss
               if (waiting(pending_tbl[i].first_wait) &&
                   pending_tbl[i].first_wait == {1'b0, c.dest}) begin
                  pending_tbl[i].first = c.first;
                  pending_tbl[i].first_wait = READY_TAG;
               end else if (waiting(pending_tbl[i].second_wait) &&
                            pending_tbl[i].second_wait == {1'b0, c.dest}) begin
                  pending_tbl[i].second = c.first;
                  pending_tbl[i].second_wait = READY_TAG;
               end
            end
         end
         rswi_pkg::OP_CLEAR: clear_tables();
         rswi_pkg::OP_TICK: begin
            if (c.exec_free) begin
               foreach (committed_tbl[i]) begin
                  if (!committed_tbl[i].busy) continue;
                  imm_form = committed_tbl[i].kind[0];
                  if (waiting(committed_tbl[i].first_wait)) continue;
                  if (!imm_form && waiting(committed_tbl[i].second_wait)) continue;
                  r.status = rswi_pkg::STATUS_ISSUED;
                  r.opcode = committed_tbl[i].opcode;
                  r.first = committed_tbl[i].first;
                  r.second = imm_form ? committed_tbl[i].imm : committed_tbl[i].second;
                  r.tag = committed_tbl[i].tag;
                  r.to_ls = committed_tbl[i].kind[1];
                  r.last = 1'b0;
                  pending_tbl[i].busy = 1'b0;
                  if (keep) expected_issues.push_back(r);
                  n++;
               end
               if (keep && n > 0) expected_issues[$].last = 1'b1;
            end
            committed_tbl = pending_tbl;
         end
         default: begin
         end
      endcase
   endfunction

   // send one command beat; model and expectations advance on acceptance
   task automatic send_cmd(cmd_type c, int gap, bit has_fixed, issue_type fixed);
      while (gap > 0) begin
         req_tvalid = 1'b0;
         @(negedge clock);
         gap--;
      end
      req_tuser = c.op;
      req_tdata = {6'b0, c.exec_free, c.dest, c.imm, c.second_wait, c.first_wait,
                   c.second, c.first, c.is_load, c.uses_imm, c.opcode};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      station_step(c, !has_fixed);
      if (has_fixed) expected_issues.push_back(fixed);
      commands_sent++;
      @(negedge clock);
   endtask

   // mostly a small tag pool so that wakeups hit; sometimes any tag
   function automatic logic [5:0] random_wait();
      logic [4:0] t;
      t = ($urandom_range(0, 4) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) return {1'b1, 5'($urandom())};
      return {1'b0, t};
   endfunction

   function automatic cmd_type random_cmd();
      cmd_type c;
      int pick;
      c.opcode = 6'($urandom_range(0, 63));
      c.uses_imm = 1'($urandom_range(0, 1));
      c.is_load = 1'($urandom_range(0, 1));
      c.first = $urandom();
      c.second = $urandom();
      c.imm = $urandom();
      c.first_wait = random_wait();
      c.second_wait = random_wait();
      c.dest = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 7));
      c.exec_free = ($urandom_range(0, 4) != 0);
      pick = int'($urandom_range(0, 99));
      if (pick < 40) c.op = rswi_pkg::OP_INSERT;
      else if (pick < 65) c.op = rswi_pkg::OP_WAKEUP;
      else if (pick < 98) c.op = rswi_pkg::OP_TICK;
      else c.op = rswi_pkg::OP_CLEAR;
      return c;
   endfunction

   function automatic cmd_type mk(logic [1:0] op, logic [5:0] opc, logic ui, logic il,
                                  logic [31:0] a, logic [31:0] b, logic [5:0] fw,
                                  logic [5:0] sw, logic [31:0] imm, logic [4:0] dest,
                                  logic ef);
      cmd_type c;
      c = '{op: op, opcode: opc, uses_imm: ui, is_load: il, first: a, second: b,
            first_wait: fw, second_wait: sw, imm: imm, dest: dest, exec_free: ef};
      return c;
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin : receiver
      int stall;
      bit calm;
      issue_type got;
      stall = 0;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end
         rsp_tready = (stall == 0) && !reset;
         if (stall > 0) stall--;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, opcode: rsp_tdata[5:0], first: rsp_tdata[37:6],
                    second: rsp_tdata[69:38], tag: rsp_tdata[74:70],
                    to_ls: rsp_tdata[75], last: rsp_tlast};
            beats_seen++;
            if (rsp_tuser == rswi_pkg::STATUS_REJECTED) rejects_seen++;
            if (expected_issues.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %p", got);
            end else if (got !== expected_issues[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", expected_issues[0], got);
               void'(expected_issues.pop_front());
            end else begin
               void'(expected_issues.pop_front());
            end
            if ($urandom_range(0, 29) == 0) calm = !calm;
            stall = calm ? 0 : int'($urandom_range(0, 18));
         end
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress, %0d results outstanding", expected_issues.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin : driver
      cmd_type stim [$];
      bit fixed_row [$];
      issue_type fixed_val [$];
      issue_type none;
      issue_type issue0;
      bit calm;
      int gap;
      none = '0;
      clear_tables();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      issue0 = '{status: rswi_pkg::STATUS_ISSUED, opcode: 6'd0, first: 32'h1234_5678,
                 second: 32'hffff_ffff, tag: 5'd0, to_ls: 1'b1, last: 1'b1};
      // tick on an empty station: nothing issues
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      // extremes, second operand waiting on tag 31
      stim.push_back(mk(rswi_pkg::OP_INSERT, 63, 0, 0, '1, '0, READY_TAG, 6'd31, '1, 31, 0));
      // second insert before a tick lands in the same slot
      stim.push_back(mk(rswi_pkg::OP_INSERT, 0, 1, 1, '0, '1, 6'd0, 6'd5, '1, 0, 0));
      // busy execution unit: nothing issues, pending is committed
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 0));
      stim.push_back(mk(rswi_pkg::OP_WAKEUP, 0, 0, 0, 32'h1234_5678, 0, 0, 0, 0, 0, 0));
      stim.push_back(mk(rswi_pkg::OP_WAKEUP, 0, 0, 0, 32'h0bad_f00d, 0, 0, 0, 0, 5, 0));
      // committed copy still waits: no issue, then the woken entry issues
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      // register form waiting on a tag that also fills its first wait
      stim.push_back(mk(rswi_pkg::OP_INSERT, 21, 0, 1, 32'h5555_5555, 32'haaaa_aaaa,
                        6'd9, 6'd9, 32'h0f0f_0f0f, 17, 0));
      stim.push_back(mk(rswi_pkg::OP_INSERT, 42, 1, 0, 32'haaaa_aaaa, 32'h5555_5555,
                        6'h20, 6'd31, 32'hf0f0_f0f0, 14, 1));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      stim.push_back(mk(rswi_pkg::OP_INSERT, 7, 0, 0, 32'h8000_0001, 32'h7fff_fffe,
                        6'h2a, 6'h15, 32'h0, 21, 0));
      stim.push_back(mk(rswi_pkg::OP_WAKEUP, 0, 0, 0, 32'hdead_beef, 0, 0, 0, 0, 9, 0));
      stim.push_back(mk(rswi_pkg::OP_WAKEUP, 0, 0, 0, 32'hcafe_f00d, 0, 0, 0, 0, 9, 0));
      stim.push_back(mk(rswi_pkg::OP_WAKEUP, 0, 0, 0, 32'h0000_ffff, 0, 0, 0, 0, 21, 0));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      stim.push_back(mk(rswi_pkg::OP_INSERT, 3, 0, 0, 1, 2, 6'd30, 6'd30, 3, 4, 0));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      stim.push_back(mk(rswi_pkg::OP_CLEAR, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 0));
      stim.push_back(mk(rswi_pkg::OP_TICK, 0, 0, 0, 0, 0, READY_TAG, READY_TAG, 0, 0, 1));
      foreach (stim[i]) begin
         fixed_row.push_back(i == 7);
         fixed_val.push_back(i == 7 ? issue0 : none);
      end

      calm = 1'b0;
      foreach (stim[i]) begin
         gap = calm ? 0 : int'($urandom_range(0, 18));
         send_cmd(stim[i], gap, fixed_row[i], fixed_val[i]);
      end

      // random part
      for (int k = 0; k < RANDOM_BEATS; k++) begin
         if (k == 150) long_hold_req = 1'b1;
         if ($urandom_range(0, 29) == 0) calm = !calm;
         gap = calm ? 0 : int'($urandom_range(0, 18));
         send_cmd(random_cmd(), gap, 1'b0, none);
      end
      req_tvalid = 1'b0;

      while (expected_issues.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d commands, checked %0d response beats (%0d full-station rejects)",
               commands_sent, beats_seen, rejects_seen);
      if (mismatches == 0 && expected_issues.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
